// ===== design/bchc_pkg.sv =====
// Shared types, constants and syndrome helpers for the BCH(63,51) codec.
`default_nettype none
package bchc_pkg;

	localparam int CODE_W = 63;
	localparam int DATA_W = 51;
	localparam int GEN_DEG = 12;
	localparam int STEPS_PER_CELL = 3;
	localparam int N_CELLS = (CODE_W - GEN_DEG) / STEPS_PER_CELL;
	localparam logic [GEN_DEG:0] GEN_POLY = 13'h1247;

	typedef logic [CODE_W-1:0] word_t;
	typedef logic [GEN_DEG-1:0] syn_t;

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAN    = 2'd0,
		ST_FIXED    = 2'd1,
		ST_NO_MATCH = 2'd2
	} status_t;

	typedef struct packed {
		op_t   op;
		word_t word;
		word_t rem;
	} div_t;

	function automatic syn_t bit_syndrome(input int pos);
		word_t r;
		r = word_t'(1) << pos;
		for (int b = CODE_W - 1; b >= GEN_DEG; b--) begin
			if (r[b]) begin
				r = r ^ (word_t'(GEN_POLY) << (b - GEN_DEG));
			end
		end
		return r[GEN_DEG-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/bchc_if.sv =====
// Handshake channels for codec commands and results.
`default_nettype none
interface bchc_cmd_if;
	logic                  valid;
	logic                  ready;
	logic                  opcode;
	logic [bchc_pkg::CODE_W-1:0] word_in;

	modport source (output valid, output opcode, output word_in, input ready);
	modport sink (input valid, input opcode, input word_in, output ready);
endinterface

interface bchc_res_if;
	logic                  valid;
	logic                  ready;
	logic [bchc_pkg::CODE_W-1:0] word_out;
	logic [1:0]            status;

	modport source (output valid, output word_out, output status, input ready);
	modport sink (input valid, input word_out, input status, output ready);
endinterface
`default_nettype wire

// ===== design/bchc_cell.sv =====
// One division cell: a few long-division steps on the running remainder.
`default_nettype none
module bchc_cell #(
	parameter int HI_BIT = 62,
	parameter int STEPS = 3
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire bchc_pkg::div_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output bchc_pkg::div_t     out_data
);

	logic           valid_q;
	bchc_pkg::div_t data_q;
	bchc_pkg::div_t nxt;

	always_comb begin
		bchc_pkg::word_t r;
		r = in_data.rem;
		for (int k = 0; k < STEPS; k++) begin
			if (r[HI_BIT-k]) begin
				r = r ^ (bchc_pkg::word_t'(bchc_pkg::GEN_POLY) << (HI_BIT - k - bchc_pkg::GEN_DEG));
			end
		end
		nxt = in_data;
		nxt.rem = r;
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;

endmodule
`default_nettype wire

// ===== design/bchc_corr.sv =====
// Syndrome match and single-bit correction stages, ending in the result register.
`default_nettype none
module bchc_corr (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire bchc_pkg::div_t in_data,
	bchc_res_if.source     res
);

	localparam int W = bchc_pkg::CODE_W;
	localparam int G = bchc_pkg::GEN_DEG;

	bchc_pkg::syn_t  syn;
	bchc_pkg::word_t hit;

	logic            v_s1;
	bchc_pkg::op_t   op_s1;
	bchc_pkg::word_t word_s1;
	bchc_pkg::syn_t  syn_s1;
	bchc_pkg::word_t hit_s1;

	logic            v_s2;
	bchc_pkg::word_t word_out_s2;
	bchc_pkg::status_t status_s2;

	logic            rdy1;
	logic            rdy2;

	bchc_pkg::word_t smear;
	bchc_pkg::word_t pick;
	bchc_pkg::word_t fixed;
	bchc_pkg::word_t word_nxt;
	bchc_pkg::status_t status_nxt;

	assign syn = in_data.rem[G-1:0];

	for (genvar p = 0; p < W; p++) begin : g_match
		localparam bchc_pkg::syn_t BIT_SYN = bchc_pkg::bit_syndrome(p);
		assign hit[p] = (syn == BIT_SYN);
	end

	assign rdy2 = !v_s2 || res.ready;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			op_s1 <= in_data.op;
			word_s1 <= in_data.word;
			syn_s1 <= syn;
			hit_s1 <= hit;
		end
	end

	always_comb begin
		smear = hit_s1;
		smear = smear | (smear >> 1);
		smear = smear | (smear >> 2);
		smear = smear | (smear >> 4);
		smear = smear | (smear >> 8);
		smear = smear | (smear >> 16);
		smear = smear | (smear >> 32);
		pick = hit_s1 & ~(smear >> 1);
		fixed = word_s1 ^ pick;
		if (op_s1 == bchc_pkg::OP_ENCODE) begin
			word_nxt = word_s1 | bchc_pkg::word_t'(syn_s1);
			status_nxt = bchc_pkg::ST_CLEAN;
		end else begin
			word_nxt = bchc_pkg::word_t'(fixed[W-1:G]);
			if (syn_s1 == '0) begin
				status_nxt = bchc_pkg::ST_CLEAN;
			end else if (hit_s1 != '0) begin
				status_nxt = bchc_pkg::ST_FIXED;
			end else begin
				status_nxt = bchc_pkg::ST_NO_MATCH;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy2) begin
			word_out_s2 <= word_nxt;
			status_s2 <= status_nxt;
		end
	end

	assign res.valid = v_s2;
	assign res.word_out = word_out_s2;
	assign res.status = status_s2;

endmodule
`default_nettype wire

// ===== design/bch_63_51_codec.sv =====
// Top level of the BCH(63,51) encoder and single-error decoder.
// One item enters per cycle while results are taken, and passes a row of 17 division
// cells, each taking three steps of the long division by the generator 0x1247, followed
// by a syndrome-match stage and the result register. Every stage has its own valid bit,
// so a stalled result only holds the stages behind it that are full.
`default_nettype none
module bch_63_51_codec (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bchc_cmd_if.sink   cmd,
	bchc_res_if.source res
);

	localparam int N = bchc_pkg::N_CELLS;
	localparam int S = bchc_pkg::STEPS_PER_CELL;

	logic           ch_valid [N+1];
	logic           ch_ready [N+1];
	bchc_pkg::div_t ch_data  [N+1];

	bchc_pkg::word_t start_word;

	always_comb begin
		if (bchc_pkg::op_t'(cmd.opcode) == bchc_pkg::OP_ENCODE) begin
			start_word = {cmd.word_in[bchc_pkg::DATA_W-1:0], bchc_pkg::syn_t'(0)};
		end else begin
			start_word = cmd.word_in;
		end
	end

	assign ch_valid[0] = cmd.valid;
	assign cmd.ready = ch_ready[0];
	assign ch_data[0].op = bchc_pkg::op_t'(cmd.opcode);
	assign ch_data[0].word = start_word;
	assign ch_data[0].rem = start_word;

	for (genvar i = 0; i < N; i++) begin : g_cell
		bchc_cell #(
			.HI_BIT(bchc_pkg::CODE_W - 1 - i * S),
			.STEPS(S)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_valid(ch_valid[i]),
			.in_ready(ch_ready[i]),
			.in_data(ch_data[i]),
			.out_valid(ch_valid[i+1]),
			.out_ready(ch_ready[i+1]),
			.out_data(ch_data[i+1])
		);
	end

	bchc_corr u_corr (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(ch_valid[N]),
		.in_ready(ch_ready[N]),
		.in_data(ch_data[N]),
		.res(res)
	);

endmodule
`default_nettype wire
